[hdl/shape_id_grid_collision_assert.svh]
// Assertion macros for the shape id grid collision block.
// Used by the top level; expects signals clk and rst_n in scope.
`ifndef SHAPE_ID_GRID_COLLISION_ASSERT_SVH
`define SHAPE_ID_GRID_COLLISION_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define SIGC_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("grid collision assertion failed");

// Next-cycle implication, disabled during reset.
`define SIGC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("grid collision assertion failed");

`endif

[hdl/sigc_pkg.sv]
// Shared types and constants of the shape id grid collision block.
// No dependencies.
`default_nettype none

package sigc_pkg;

    localparam int MAX_COLS_DEF = 128;
    localparam int MAX_ROWS_DEF = 128;
    localparam int ID_BITS_DEF  = 8;

    localparam int CFG_W = 8;
    localparam logic [CFG_W-1:0] GRID_SIZE_RESET = 8'd128;

    // configuration register indexes
    typedef enum logic {
        CFG_GRID_WIDTH  = 1'b0,
        CFG_GRID_HEIGHT = 1'b1
    } cfg_index_t;

    // operation codes
    typedef enum logic [1:0] {
        FUNC_CLEAR = 2'd0,
        FUNC_DRAW  = 2'd1,
        FUNC_CHECK = 2'd2
    } func_t;

    // clear sequencer states
    typedef enum logic {
        SEQ_IDLE,
        SEQ_SWEEP
    } seq_state_t;

    // sequencer status toward the datapath
    typedef struct packed {
        logic sweep;
        logic busy;
    } seq_stat_t;

endpackage

`default_nettype wire

[hdl/shape_id_grid_collision.sv]
// Top level of the shape id grid collision block: point pipeline and run state.
// Depends on sigc_pkg, sigc_cell_ram, sigc_clear_seq and the assertion header.
// Draw and check words are taken one per cycle while busy is low; a check with last_point
// raises done for one cycle via the stage 1 word, stage 2 and done registers. done cannot
// be stalled. A clear holds busy in the word register, then while the sweep zeroes one
// cell per cycle. Reset starts the same sweep.
`default_nettype none

`include "shape_id_grid_collision_assert.svh"

module shape_id_grid_collision #(
    parameter int MAX_COLS = sigc_pkg::MAX_COLS_DEF,
    parameter int MAX_ROWS = sigc_pkg::MAX_ROWS_DEF,
    parameter int ID_BITS  = sigc_pkg::ID_BITS_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    // command word
    input  logic                       start,
    output logic                       busy,
    input  logic [1:0]                 func,
    input  logic signed [8:0]          base_x,
    input  logic signed [8:0]          base_y,
    input  logic signed [7:0]          offset_x,
    input  logic signed [7:0]          offset_y,
    input  logic [7:0]                 object_id,
    input  logic                       last_point,
    // result word
    output logic                       done,
    output logic                       hit,
    output logic [7:0]                 hit_id,
    // configuration
    input  logic                       cfg_we,
    input  logic                       cfg_index,
    input  logic [sigc_pkg::CFG_W-1:0] cfg_data
);
    import sigc_pkg::*;

    localparam int DEPTH  = MAX_COLS * MAX_ROWS;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int PROD_W = ADDR_W + 10;
    // working width for id arithmetic, at least as wide as the id field
    localparam int IDW    = (ID_BITS > 8) ? ID_BITS : 8;

    // ------------------------------------------------------------------
    // Configuration registers and effective grid size
    // ------------------------------------------------------------------
    logic [CFG_W-1:0] grid_width_reg, grid_height_reg;
    logic [CFG_W-1:0] eff_w, eff_h;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_width_reg  <= GRID_SIZE_RESET;
            grid_height_reg <= GRID_SIZE_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_GRID_WIDTH:  grid_width_reg  <= cfg_data;
                CFG_GRID_HEIGHT: grid_height_reg <= cfg_data;
                default:         ;
            endcase
        end
    end

    // clamp to the physical grid; sizes above 255 never clamp an 8-bit value
    assign eff_w = (11'(grid_width_reg) < 11'(MAX_COLS)) ? grid_width_reg
                                                         : CFG_W'(MAX_COLS);
    assign eff_h = (11'(grid_height_reg) < 11'(MAX_ROWS)) ? grid_height_reg
                                                          : CFG_W'(MAX_ROWS);

    // ------------------------------------------------------------------
    // Stage 1: accepted word register
    // ------------------------------------------------------------------
    seq_stat_t         seq_stat;
    logic [ADDR_W-1:0] sweep_addr;
    logic              accept;
    logic              clear_req;

    logic                s1_valid_reg;
    logic [1:0]          s1_func_reg;
    logic signed [8:0]   s1_base_x_reg, s1_base_y_reg;
    logic signed [7:0]   s1_offset_x_reg, s1_offset_y_reg;
    logic [7:0]          s1_object_id_reg;
    logic                s1_last_reg;

    assign busy   = seq_stat.busy;
    assign accept = start && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_func_reg      <= func;
            s1_base_x_reg    <= base_x;
            s1_base_y_reg    <= base_y;
            s1_offset_x_reg  <= offset_x;
            s1_offset_y_reg  <= offset_y;
            s1_object_id_reg <= object_id;
            s1_last_reg      <= last_point;
        end
    end

    assign clear_req = s1_valid_reg && (s1_func_reg == FUNC_CLEAR);

    // point position and bounds check
    logic signed [9:0]   s1_x, s1_y;
    logic                s1_inside;
    logic [PROD_W-1:0]   s1_row_base;
    logic [ADDR_W-1:0]   s1_addr;
    logic [IDW-1:0]      s1_id_w;
    logic [ID_BITS-1:0]  s1_cell_val;

    assign s1_x = 10'(s1_base_x_reg) + 10'(s1_offset_x_reg);
    assign s1_y = 10'(s1_base_y_reg) + 10'(s1_offset_y_reg);

    assign s1_inside = !s1_x[9] && !s1_y[9]
                    && (s1_x[8:0] < {1'b0, eff_w})
                    && (s1_y[8:0] < {1'b0, eff_h});

    // fixed row pitch of MAX_COLS, independent of the configured width
    assign s1_row_base = PROD_W'(s1_y[8:0]) * PROD_W'(MAX_COLS);
    assign s1_addr     = ADDR_W'(s1_row_base + PROD_W'(s1_x[8:0]));

    // stored value is id+1, wrapping at the cell width (a wrap draws empty)
    assign s1_id_w     = IDW'(s1_object_id_reg);
    assign s1_cell_val = ID_BITS'(s1_id_w + IDW'(1));

    // ------------------------------------------------------------------
    // Cell memory and clear sweep
    // ------------------------------------------------------------------
    logic               mem_we;
    logic [ADDR_W-1:0]  mem_addr;
    logic [ID_BITS-1:0] mem_wdata;
    logic [ID_BITS-1:0] mem_rdata;

    sigc_clear_seq #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_clear_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .clear_req  (clear_req),
        .stat       (seq_stat),
        .sweep_addr (sweep_addr)
    );

    // the sweep owns the port; no word sits in stage 1 while it runs
    always_comb
    begin
        if (seq_stat.sweep)
        begin
            mem_we    = 1'b1;
            mem_addr  = sweep_addr;
            mem_wdata = '0;
        end
        else
        begin
            mem_we    = s1_valid_reg && (s1_func_reg == FUNC_DRAW) && s1_inside;
            mem_addr  = s1_addr;
            mem_wdata = s1_cell_val;
        end
    end

    sigc_cell_ram #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W),
        .DATA_W (ID_BITS)
    ) u_cell_ram (
        .clk   (clk),
        .we    (mem_we),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    // ------------------------------------------------------------------
    // Stage 2: check word sees read data, updates run state
    // Any draw ahead of the check has already written, so no forwarding needed.
    // ------------------------------------------------------------------
    logic s2_check_reg, s2_last_reg, s2_inside_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_check_reg <= 1'b0;
        end
        else
        begin
            s2_check_reg <= s1_valid_reg && (s1_func_reg == FUNC_CHECK);
        end
    end

    always_ff @(posedge clk)
    begin
        s2_last_reg   <= s1_last_reg;
        s2_inside_reg <= s1_inside;
    end

    logic               run_hit_reg, run_hit_next;
    logic [7:0]         run_hit_id_reg, run_hit_id_next;
    logic               done_reg, done_next;
    logic               hit_reg, hit_next;
    logic [7:0]         hit_id_reg, hit_id_next;
    logic               found;
    logic               cur_hit;
    logic [7:0]         cur_id;
    logic [ID_BITS-1:0] cell_less;

    // first occupied cell of the run wins; later points are ignored
    assign found     = s2_check_reg && s2_inside_reg && !run_hit_reg
                    && (mem_rdata != '0);
    assign cell_less = mem_rdata - ID_BITS'(1);
    assign cur_hit   = run_hit_reg || found;
    assign cur_id    = found ? 8'(IDW'(cell_less)) : run_hit_id_reg;

    always_comb
    begin
        run_hit_next    = run_hit_reg;
        run_hit_id_next = run_hit_id_reg;
        done_next       = 1'b0;
        hit_next        = hit_reg;
        hit_id_next     = hit_id_reg;
        if (s2_check_reg)
        begin
            if (s2_last_reg)
            begin
                // end of run: report and re-arm
                done_next       = 1'b1;
                hit_next        = cur_hit;
                hit_id_next     = cur_id;
                run_hit_next    = 1'b0;
                run_hit_id_next = 8'd0;
            end
            else
            begin
                run_hit_next    = cur_hit;
                run_hit_id_next = cur_id;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_hit_reg    <= 1'b0;
            run_hit_id_reg <= 8'd0;
            done_reg       <= 1'b0;
        end
        else
        begin
            run_hit_reg    <= run_hit_next;
            run_hit_id_reg <= run_hit_id_next;
            done_reg       <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hit_reg    <= hit_next;
        hit_id_reg <= hit_id_next;
    end

    assign done   = done_reg;
    assign hit    = hit_reg;
    assign hit_id = hit_id_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // a run that found nothing reports id zero
    `SIGC_ASSERT_IMPL(a_nohit_zero_id, done && !hit, hit_id == 8'd0)
    // nothing enters the point pipeline while the sweep owns the memory
    `SIGC_ASSERT_IMPL(a_sweep_excl, seq_stat.sweep, !s1_valid_reg)
    // an accepted clear raises busy in the next cycle
    `SIGC_ASSERT_NEXT(a_clear_busy, accept && (func == FUNC_CLEAR), busy)

endmodule

`default_nettype wire

[hdl/sigc_cell_ram.sv]
// Single-port cell memory, read-first, registered read data.
// Depends on nothing.
`default_nettype none

module sigc_cell_ram #(
    parameter int DEPTH  = 16384,
    parameter int ADDR_W = 14,
    parameter int DATA_W = 8
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] addr,
    input  logic [DATA_W-1:0] wdata,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

`default_nettype wire

[hdl/sigc_clear_seq.sv]
// Clear sequencer: walks every cell address once after reset and per clear op.
// Depends on sigc_pkg.
`default_nettype none

module sigc_clear_seq #(
    parameter int DEPTH  = 16384,
    parameter int ADDR_W = 14
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  clear_req,
    output sigc_pkg::seq_stat_t   stat,
    output logic [ADDR_W-1:0]     sweep_addr
);
    import sigc_pkg::*;

    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);

    seq_state_t        state_reg, state_next;
    logic [ADDR_W-1:0] cnt_reg, cnt_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= SEQ_SWEEP;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        stat.sweep = 1'b0;
        stat.busy  = clear_req;
        case (state_reg)
            SEQ_IDLE:
            begin
                if (clear_req)
                begin
                    state_next = SEQ_SWEEP;
                    cnt_next   = '0;
                end
            end
            SEQ_SWEEP:
            begin
                stat.sweep = 1'b1;
                stat.busy  = 1'b1;
                if (cnt_reg == LAST_ADDR)
                begin
                    state_next = SEQ_IDLE;
                    cnt_next   = '0;
                end
                else
                begin
                    cnt_next = cnt_reg + ADDR_W'(1);
                end
            end
            default:
            begin
                state_next = SEQ_IDLE;
            end
        endcase
    end

    assign sweep_addr = cnt_reg;

endmodule

`default_nettype wire
